[src/escape_key_decoder_cursor_tracker_unit_assert.svh]
// Assertion macros used by the key decoder and cursor tracker top level.
`ifndef ESCAPE_KEY_DECODER_CURSOR_TRACKER_UNIT_ASSERT_SVH
`define ESCAPE_KEY_DECODER_CURSOR_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define EKD_ASSERT_IMPLY(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("ekd assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define EKD_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("ekd assertion failed");

`endif

[src/ekd_pkg.sv]
// Types and constants of the escape key decoder and cursor tracker.
package ekd_pkg;

   localparam int COORD_BITS = 10;
   localparam int CSR_INDEX_BITS = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_ROWS = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_COLS = 8'd1;

   localparam logic [COORD_BITS-1:0] RESET_SCREEN_ROWS = 10'd24;
   localparam logic [COORD_BITS-1:0] RESET_SCREEN_COLS = 10'd80;

   localparam logic [7:0] CHAR_ESC     = 8'h1b;
   localparam logic [7:0] CHAR_TILDE   = 8'h7e;
   localparam logic [7:0] CHAR_BRACKET = 8'h5b;
   localparam logic [7:0] CHAR_O       = 8'h4f;
   localparam logic [7:0] CHAR_Q       = 8'h71;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_B       = 8'h42;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_D       = 8'h44;
   localparam logic [7:0] CHAR_F       = 8'h46;
   localparam logic [7:0] CHAR_H       = 8'h48;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_1       = 8'h31;
   localparam logic [7:0] CHAR_3       = 8'h33;
   localparam logic [7:0] CHAR_4       = 8'h34;
   localparam logic [7:0] CHAR_5       = 8'h35;
   localparam logic [7:0] CHAR_6       = 8'h36;
   localparam logic [7:0] CHAR_7       = 8'h37;
   localparam logic [7:0] CHAR_8       = 8'h38;
   localparam logic [7:0] CHAR_9       = 8'h39;

   typedef enum logic [3:0] {
      KIND_PLAIN  = 4'd0,
      KIND_UP     = 4'd1,
      KIND_DOWN   = 4'd2,
      KIND_RIGHT  = 4'd3,
      KIND_LEFT   = 4'd4,
      KIND_PGUP   = 4'd5,
      KIND_PGDN   = 4'd6,
      KIND_HOME   = 4'd7,
      KIND_END    = 4'd8,
      KIND_DELETE = 4'd9,
      KIND_ESCAPE = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_ESC   = 2'd1,
      PHASE_FIRST = 2'd2,
      PHASE_DIGIT = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       timed_out;
   } req_type;

   typedef struct packed {
      kind_type              key_kind;
      logic [7:0]            key_byte;
      logic [COORD_BITS-1:0] cursor_row;
      logic [COORD_BITS-1:0] cursor_col;
      logic                  quit;
   } rsp_type;

   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic [7:0] key_byte;
   } decode_type;

   function automatic kind_type letter_kind(input logic [7:0] b, input logic arrows);
      kind_type k;
      k = KIND_ESCAPE;
      if (arrows && b == CHAR_A) k = KIND_UP;
      else if (arrows && b == CHAR_B) k = KIND_DOWN;
      else if (arrows && b == CHAR_C) k = KIND_RIGHT;
      else if (arrows && b == CHAR_D) k = KIND_LEFT;
      else if (b == CHAR_H) k = KIND_HOME;
      else if (b == CHAR_F) k = KIND_END;
      return k;
   endfunction

   function automatic kind_type digit_kind(input logic [7:0] d);
      kind_type k;
      k = KIND_ESCAPE;
      if (d == CHAR_1 || d == CHAR_7) k = KIND_HOME;
      else if (d == CHAR_3) k = KIND_DELETE;
      else if (d == CHAR_4 || d == CHAR_8) k = KIND_END;
      else if (d == CHAR_5) k = KIND_PGUP;
      else if (d == CHAR_6) k = KIND_PGDN;
      return k;
   endfunction

endpackage

[src/escape_key_decoder_cursor_tracker_unit.sv]
// Top level of the terminal key decoder with cursor tracker.
//
// Input channel req_: one terminal byte or a timeout event per transfer.
// Result channel rsp_: zero or one decoded key per input transfer, carrying
// the key kind, the plain byte, the cursor position after the key and the
// quit flag. Configuration channel csr_: writes the screen row and column
// counts and is always ready. The user must write it only while the block
// is idle; the block itself leaves this unchecked. Each input transfer is
// decoded in the cycle it is accepted and its result is registered in the
// output buffer. One input transfer is taken every cycle while req_ready is
// high. The parse state and cursor update at the input transfer itself,
// through one level of compare and add logic. A two-entry output buffer
// (result register plus skid register) lets the input side keep going
// while a result waits; req_ready drops only when both entries are full
// and the receiver stalls, and returns in the cycle after a result transfer.
// Synchronous reset returns the parser to idle, puts the cursor at row 0,
// column 0, sets the screen to 24 rows by 80 columns and empties the buffer.
module escape_key_decoder_cursor_tracker_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ekd_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ekd_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ekd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ekd_pkg::COORD_BITS-1:0]       csr_data
);

   `include "escape_key_decoder_cursor_tracker_unit_assert.svh"

   localparam int CB = ekd_pkg::COORD_BITS;

   logic [CB-1:0] rows_ff, cols_ff;
   logic [CB-1:0] row_ff, row_in;
   logic [CB-1:0] col_ff, col_in;
   logic [CB-1:0] row_last, col_last;
   logic          req_accept;
   logic          push;
   ekd_pkg::decode_type decode;
   ekd_pkg::rsp_type    result;
   ekd_pkg::rsp_type    out_ff, out_in;
   ekd_pkg::rsp_type    skid_ff, skid_in;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   ekd_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_payload),
      .decode (decode)
   );

   assign row_last = (rows_ff == '0) ? '0 : rows_ff - CB'(1);
   assign col_last = (cols_ff == '0) ? '0 : cols_ff - CB'(1);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (decode.emit) begin
         unique case (decode.kind)
            ekd_pkg::KIND_UP:    if (row_ff > '0) row_in = row_ff - CB'(1);
            ekd_pkg::KIND_DOWN:  if (row_ff < row_last) row_in = row_ff + CB'(1);
            ekd_pkg::KIND_LEFT:  if (col_ff > '0) col_in = col_ff - CB'(1);
            ekd_pkg::KIND_RIGHT: if (col_ff < col_last) col_in = col_ff + CB'(1);
            ekd_pkg::KIND_HOME:  col_in = '0;
            ekd_pkg::KIND_END:   col_in = col_last;
            ekd_pkg::KIND_PGUP:  row_in = '0;
            ekd_pkg::KIND_PGDN:  row_in = row_last;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.key_kind   = decode.kind;
      result.key_byte   = decode.key_byte;
      result.cursor_row = row_in;
      result.cursor_col = col_in;
      result.quit       = (decode.kind == ekd_pkg::KIND_ESCAPE) ||
                          (decode.kind == ekd_pkg::KIND_PLAIN &&
                           decode.key_byte == ekd_pkg::CHAR_Q);
   end

   assign push = req_accept && decode.emit;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && !rsp_ready) begin
         if (push) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_in       = result;
         skid_valid_in = push;
      end else begin
         out_in       = result;
         out_valid_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= ekd_pkg::RESET_SCREEN_ROWS;
         cols_ff       <= ekd_pkg::RESET_SCREEN_COLS;
         row_ff        <= '0;
         col_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ekd_pkg::CSR_SCREEN_ROWS) rows_ff <= csr_data;
            else if (csr_index == ekd_pkg::CSR_SCREEN_COLS) cols_ff <= csr_data;
         end
         if (req_accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `EKD_ASSERT_IMPLY(a_skid_needs_out, skid_valid_ff, out_valid_ff)
   `EKD_ASSERT_NEXT(a_skid_drains, skid_valid_ff && rsp_ready, out_valid_ff)
   `EKD_ASSERT_IMPLY(a_quit_matches_key, out_valid_ff, out_ff.quit == ((out_ff.key_kind == ekd_pkg::KIND_ESCAPE) || (out_ff.key_kind == ekd_pkg::KIND_PLAIN && out_ff.key_byte == ekd_pkg::CHAR_Q)))
   `EKD_ASSERT_IMPLY(a_byte_only_plain, out_valid_ff && out_ff.key_kind != ekd_pkg::KIND_PLAIN, out_ff.key_byte == 8'd0)

endmodule

[src/ekd_decoder.sv]
// Escape sequence parser: holds the parse state and classifies each input transfer.
module ekd_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ekd_pkg::req_type    req,
   output ekd_pkg::decode_type decode
);

   ekd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] digit_ff, digit_in;
   logic       is_digit;

   assign is_digit = (req.byte_value >= ekd_pkg::CHAR_0) &&
                     (req.byte_value <= ekd_pkg::CHAR_9);

   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      digit_in = digit_ff;
      unique case (phase_ff)
         ekd_pkg::PHASE_IDLE: begin
            if (!req.timed_out && req.byte_value == ekd_pkg::CHAR_ESC) begin
               phase_in = ekd_pkg::PHASE_ESC;
            end
         end
         ekd_pkg::PHASE_ESC: begin
            if (req.timed_out) begin
               phase_in = ekd_pkg::PHASE_IDLE;
            end else begin
               phase_in = ekd_pkg::PHASE_FIRST;
               first_in = req.byte_value;
            end
         end
         ekd_pkg::PHASE_FIRST: begin
            if (!req.timed_out && first_ff == ekd_pkg::CHAR_BRACKET && is_digit) begin
               phase_in = ekd_pkg::PHASE_DIGIT;
               digit_in = req.byte_value;
            end else begin
               phase_in = ekd_pkg::PHASE_IDLE;
            end
         end
         ekd_pkg::PHASE_DIGIT: begin
            phase_in = ekd_pkg::PHASE_IDLE;
         end
         default: begin
            phase_in = ekd_pkg::PHASE_IDLE;
         end
      endcase
   end

   always_comb begin
      decode.emit     = 1'b1;
      decode.kind     = ekd_pkg::KIND_ESCAPE;
      decode.key_byte = 8'd0;
      unique case (phase_ff)
         ekd_pkg::PHASE_IDLE: begin
            if (req.timed_out || req.byte_value == ekd_pkg::CHAR_ESC) begin
               decode.emit = 1'b0;
            end else begin
               decode.kind     = ekd_pkg::KIND_PLAIN;
               decode.key_byte = req.byte_value;
            end
         end
         ekd_pkg::PHASE_ESC: begin
            decode.emit = req.timed_out;
         end
         ekd_pkg::PHASE_FIRST: begin
            if (!req.timed_out) begin
               if (first_ff == ekd_pkg::CHAR_BRACKET) begin
                  decode.emit = !is_digit;
                  decode.kind = ekd_pkg::letter_kind(req.byte_value, 1'b1);
               end else if (first_ff == ekd_pkg::CHAR_O) begin
                  decode.kind = ekd_pkg::letter_kind(req.byte_value, 1'b0);
               end
            end
         end
         ekd_pkg::PHASE_DIGIT: begin
            if (!req.timed_out && req.byte_value == ekd_pkg::CHAR_TILDE) begin
               decode.kind = ekd_pkg::digit_kind(digit_ff);
            end
         end
         default: begin
            decode.emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ekd_pkg::PHASE_IDLE;
         first_ff <= 8'd0;
         digit_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         digit_ff <= digit_in;
      end
   end

endmodule

[sim/tb_escape_key_decoder_cursor_tracker_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the escape key decoder and cursor tracker unit.
module tb_escape_key_decoder_cursor_tracker_unit;

   localparam int CLOCK_PERIOD = 10;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_COUNT = 10;
   localparam int FIXED_PHASES = 7;
   localparam int PHASE_ITEMS = 115;
   localparam int STEADY_PHASE = 3;
   localparam int DIRECTED_COUNT = 47;
   localparam logic [ekd_pkg::CSR_INDEX_BITS-1:0] CSR_INDEX_UNUSED = 8'hff;

   typedef enum logic [1:0] {
      ROW_SILENT,
      ROW_TYPED,
      ROW_PREDICTED
   } row_check_type;

   typedef struct packed {
      ekd_pkg::req_type stim;
      row_check_type    check;
      ekd_pkg::rsp_type key;
   } directed_row_type;

   localparam ekd_pkg::rsp_type NO_KEY = '0;
   localparam ekd_pkg::req_type IN_ESC = '{ekd_pkg::CHAR_ESC, 1'b0};
   localparam ekd_pkg::req_type IN_BRACKET = '{ekd_pkg::CHAR_BRACKET, 1'b0};
   localparam ekd_pkg::req_type IN_O = '{ekd_pkg::CHAR_O, 1'b0};
   localparam ekd_pkg::req_type IN_TILDE = '{ekd_pkg::CHAR_TILDE, 1'b0};

   localparam logic [7:0] SEQ_LETTERS [6] = '{
      ekd_pkg::CHAR_A, ekd_pkg::CHAR_B, ekd_pkg::CHAR_C,
      ekd_pkg::CHAR_D, ekd_pkg::CHAR_H, ekd_pkg::CHAR_F
   };
   localparam logic [7:0] NOISE_BYTES [8] = '{
      ekd_pkg::CHAR_ESC, ekd_pkg::CHAR_BRACKET, ekd_pkg::CHAR_O, ekd_pkg::CHAR_TILDE,
      ekd_pkg::CHAR_1, ekd_pkg::CHAR_9, ekd_pkg::CHAR_H, ekd_pkg::CHAR_A
   };

   localparam logic [ekd_pkg::COORD_BITS-1:0] FIXED_ROWS [FIXED_PHASES] =
      '{10'd0, 10'd1023, 10'd1, 10'd3, 10'd2, 10'd1023, 10'd24};
   localparam logic [ekd_pkg::COORD_BITS-1:0] FIXED_COLS [FIXED_PHASES] =
      '{10'd0, 10'd1023, 10'd1, 10'd5, 10'd1023, 10'd2, 10'd80};

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{8'h00, 1'b0}, ROW_TYPED,
        '{ekd_pkg::KIND_PLAIN, 8'h00, 10'd0, 10'd0, 1'b0}},
      '{'{8'hff, 1'b0}, ROW_TYPED,
        '{ekd_pkg::KIND_PLAIN, 8'hff, 10'd0, 10'd0, 1'b0}},
      '{'{ekd_pkg::CHAR_Q, 1'b0}, ROW_TYPED,
        '{ekd_pkg::KIND_PLAIN, ekd_pkg::CHAR_Q, 10'd0, 10'd0, 1'b1}},
      '{'{8'hff, 1'b1}, ROW_SILENT, NO_KEY},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_A, 1'b0}, ROW_TYPED,
        '{ekd_pkg::KIND_UP, 8'h00, 10'd0, 10'd0, 1'b0}},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_D, 1'b0}, ROW_TYPED,
        '{ekd_pkg::KIND_LEFT, 8'h00, 10'd0, 10'd0, 1'b0}},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_B, 1'b0}, ROW_PREDICTED, NO_KEY},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_C, 1'b0}, ROW_PREDICTED, NO_KEY},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_O, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_F, 1'b0}, ROW_TYPED,
        '{ekd_pkg::KIND_END, 8'h00, 10'd1, 10'd79, 1'b0}},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_O, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_H, 1'b0}, ROW_PREDICTED, NO_KEY},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_6, 1'b0}, ROW_SILENT, NO_KEY},
      '{IN_TILDE, ROW_TYPED,
        '{ekd_pkg::KIND_PGDN, 8'h00, 10'd23, 10'd0, 1'b0}},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_5, 1'b0}, ROW_SILENT, NO_KEY},
      '{IN_TILDE, ROW_PREDICTED, NO_KEY},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_3, 1'b0}, ROW_SILENT, NO_KEY},
      '{IN_TILDE, ROW_PREDICTED, NO_KEY},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{'{8'h00, 1'b1}, ROW_TYPED,
        '{ekd_pkg::KIND_ESCAPE, 8'h00, 10'd0, 10'd0, 1'b1}},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_ESC, ROW_TYPED,
        '{ekd_pkg::KIND_ESCAPE, 8'h00, 10'd0, 10'd0, 1'b1}},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_9, 1'b0}, ROW_SILENT, NO_KEY},
      '{IN_TILDE, ROW_TYPED,
        '{ekd_pkg::KIND_ESCAPE, 8'h00, 10'd0, 10'd0, 1'b1}},
      '{IN_ESC, ROW_SILENT, NO_KEY},
      '{IN_BRACKET, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_4, 1'b0}, ROW_SILENT, NO_KEY},
      '{'{ekd_pkg::CHAR_H, 1'b0}, ROW_TYPED,
        '{ekd_pkg::KIND_ESCAPE, 8'h00, 10'd0, 10'd0, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ekd_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ekd_pkg::rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ekd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ekd_pkg::COORD_BITS-1:0] csr_data = '0;

   ekd_pkg::phase_type parse_state = ekd_pkg::PHASE_IDLE;
   logic [7:0] lead_byte = 8'h00;
   logic [7:0] seq_digit = 8'h00;
   logic [ekd_pkg::COORD_BITS-1:0] track_row = '0;
   logic [ekd_pkg::COORD_BITS-1:0] track_col = '0;
   logic [ekd_pkg::COORD_BITS-1:0] screen_rows = ekd_pkg::RESET_SCREEN_ROWS;
   logic [ekd_pkg::COORD_BITS-1:0] screen_cols = ekd_pkg::RESET_SCREEN_COLS;

   ekd_pkg::rsp_type pending_keys[$];
   int items_sent = 0;
   int mismatches = 0;
   int cycle_count = 0;
   bit steady = 1'b0;

   escape_key_decoder_cursor_tracker_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic bit decode_key(input ekd_pkg::req_type stim,
                                     output ekd_pkg::rsp_type key);
      ekd_pkg::kind_type kind;
      logic [7:0] plain;
      logic [ekd_pkg::COORD_BITS-1:0] row_last;
      logic [ekd_pkg::COORD_BITS-1:0] col_last;
      key = NO_KEY;
      plain = 8'h00;
      kind = ekd_pkg::KIND_ESCAPE;
      row_last = (screen_rows == '0) ? '0 : screen_rows - 1'b1;
      col_last = (screen_cols == '0) ? '0 : screen_cols - 1'b1;
      if (parse_state == ekd_pkg::PHASE_IDLE) begin
         if (stim.timed_out) return 1'b0;
         if (stim.byte_value == ekd_pkg::CHAR_ESC) begin
            parse_state = ekd_pkg::PHASE_ESC;
            return 1'b0;
         end
         kind = ekd_pkg::KIND_PLAIN;
         plain = stim.byte_value;
      end else if (stim.timed_out) begin
         kind = ekd_pkg::KIND_ESCAPE;
      end else if (parse_state == ekd_pkg::PHASE_ESC) begin
         lead_byte = stim.byte_value;
         parse_state = ekd_pkg::PHASE_FIRST;
         return 1'b0;
      end else if (parse_state == ekd_pkg::PHASE_FIRST) begin
         if (lead_byte == ekd_pkg::CHAR_BRACKET && stim.byte_value >= ekd_pkg::CHAR_0
               && stim.byte_value <= ekd_pkg::CHAR_9) begin
            seq_digit = stim.byte_value;
            parse_state = ekd_pkg::PHASE_DIGIT;
            return 1'b0;
         end
         if (lead_byte == ekd_pkg::CHAR_BRACKET || lead_byte == ekd_pkg::CHAR_O) begin
            case (stim.byte_value)
               ekd_pkg::CHAR_A: kind = ekd_pkg::KIND_UP;
               ekd_pkg::CHAR_B: kind = ekd_pkg::KIND_DOWN;
               ekd_pkg::CHAR_C: kind = ekd_pkg::KIND_RIGHT;
               ekd_pkg::CHAR_D: kind = ekd_pkg::KIND_LEFT;
               ekd_pkg::CHAR_H: kind = ekd_pkg::KIND_HOME;
               ekd_pkg::CHAR_F: kind = ekd_pkg::KIND_END;
               default: kind = ekd_pkg::KIND_ESCAPE;
            endcase
            // The O form carries only home and end.
            if (lead_byte == ekd_pkg::CHAR_O && kind >= ekd_pkg::KIND_UP
                  && kind <= ekd_pkg::KIND_LEFT)
               kind = ekd_pkg::KIND_ESCAPE;
         end
      end else if (stim.byte_value == ekd_pkg::CHAR_TILDE) begin
         case (seq_digit)
            ekd_pkg::CHAR_1, ekd_pkg::CHAR_7: kind = ekd_pkg::KIND_HOME;
            ekd_pkg::CHAR_3: kind = ekd_pkg::KIND_DELETE;
            ekd_pkg::CHAR_4, ekd_pkg::CHAR_8: kind = ekd_pkg::KIND_END;
            ekd_pkg::CHAR_5: kind = ekd_pkg::KIND_PGUP;
            ekd_pkg::CHAR_6: kind = ekd_pkg::KIND_PGDN;
            default: kind = ekd_pkg::KIND_ESCAPE;
         endcase
      end

      case (kind)
         ekd_pkg::KIND_UP: if (track_row != '0) track_row = track_row - 1'b1;
         ekd_pkg::KIND_DOWN: if (track_row < row_last) track_row = track_row + 1'b1;
         ekd_pkg::KIND_LEFT: if (track_col != '0) track_col = track_col - 1'b1;
         ekd_pkg::KIND_RIGHT: if (track_col < col_last) track_col = track_col + 1'b1;
         ekd_pkg::KIND_HOME: track_col = '0;
         ekd_pkg::KIND_END: track_col = col_last;
         ekd_pkg::KIND_PGUP: track_row = '0;
         ekd_pkg::KIND_PGDN: track_row = row_last;
         default: ;
      endcase
      parse_state = ekd_pkg::PHASE_IDLE;
      key.key_kind = kind;
      key.key_byte = plain;
      key.cursor_row = track_row;
      key.cursor_col = track_col;
      key.quit = (kind == ekd_pkg::KIND_ESCAPE) ||
                 (kind == ekd_pkg::KIND_PLAIN && plain == ekd_pkg::CHAR_Q);
      return 1'b1;
   endfunction

   task automatic send_item(input ekd_pkg::req_type stim, input row_check_type check,
                            input ekd_pkg::rsp_type typed_key);
      ekd_pkg::rsp_type predicted;
      bit emitted;
      while (!steady && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= stim;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!stim.timed_out || parse_state != ekd_pkg::PHASE_IDLE) items_sent++;
      emitted = decode_key(stim, predicted);
      if (check == ROW_TYPED) pending_keys.push_back(typed_key);
      else if (check == ROW_PREDICTED && emitted) pending_keys.push_back(predicted);
   endtask

   task automatic send_byte(input logic [7:0] value);
      send_item('{value, 1'b0}, ROW_PREDICTED, NO_KEY);
   endtask

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      return NOISE_BYTES[$urandom_range(0, 7)];
   endfunction

   task automatic send_random_burst();
      int pick;
      int shape;
      pick = $urandom_range(0, 99);
      shape = $urandom_range(0, 2);
      if (pick < 25) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
         send_byte(ekd_pkg::CHAR_ESC);
         if (shape == 0) begin
            send_byte(ekd_pkg::CHAR_BRACKET);
            send_byte(SEQ_LETTERS[$urandom_range(0, 5)]);
         end else if (shape == 1) begin
            send_byte(ekd_pkg::CHAR_O);
            send_byte(SEQ_LETTERS[$urandom_range(0, 5)]);
         end else begin
            send_byte(ekd_pkg::CHAR_BRACKET);
            send_byte(8'(ekd_pkg::CHAR_0 + $urandom_range(0, 9)));
            send_byte(ekd_pkg::CHAR_TILDE);
         end
      end else begin
         // Truncated or broken sequences, ended by a timeout or a stray byte.
         if ($urandom_range(0, 3) != 0) send_byte(ekd_pkg::CHAR_ESC);
         repeat ($urandom_range(0, 2)) send_byte(noise_byte());
         if ($urandom_range(0, 1) == 0)
            send_item('{8'($urandom_range(0, 255)), 1'b1}, ROW_PREDICTED, NO_KEY);
         else
            send_byte(noise_byte());
      end
   endtask

   task automatic write_csr(input logic [ekd_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [ekd_pkg::COORD_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == ekd_pkg::CSR_SCREEN_ROWS) screen_rows = value;
      else if (index == ekd_pkg::CSR_SCREEN_COLS) screen_cols = value;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase;
      int target;
      logic [ekd_pkg::COORD_BITS-1:0] rows;
      logic [ekd_pkg::COORD_BITS-1:0] cols;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].check, DIRECTED_ROWS[i].key);
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         if (phase < FIXED_PHASES) begin
            rows = FIXED_ROWS[phase];
            cols = FIXED_COLS[phase];
         end else begin
            rows = ekd_pkg::COORD_BITS'($urandom_range(1, 40));
            cols = ekd_pkg::COORD_BITS'($urandom_range(1, 120));
         end
         write_csr(ekd_pkg::CSR_SCREEN_ROWS, rows);
         write_csr(ekd_pkg::CSR_SCREEN_COLS, cols);
         write_csr(CSR_INDEX_UNUSED, ekd_pkg::COORD_BITS'($urandom_range(0, 1023)));
         csr_valid <= 1'b0;
         steady = (phase == STEADY_PHASE);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_random_burst();
      end
      wait_idle();
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin : check_keys
      ekd_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_keys.size() == 0) begin
            $error("key transfer with no pending expectation");
            mismatches++;
         end else begin
            want = pending_keys.pop_front();
            if (rsp_payload.key_kind !== want.key_kind) begin
               $error("key_kind expected %0d actual %0d", want.key_kind, rsp_payload.key_kind);
               mismatches++;
            end
            if (rsp_payload.key_byte !== want.key_byte) begin
               $error("key_byte expected %0h actual %0h", want.key_byte, rsp_payload.key_byte);
               mismatches++;
            end
            if (rsp_payload.cursor_row !== want.cursor_row) begin
               $error("cursor_row expected %0d actual %0d", want.cursor_row,
                      rsp_payload.cursor_row);
               mismatches++;
            end
            if (rsp_payload.cursor_col !== want.cursor_col) begin
               $error("cursor_col expected %0d actual %0d", want.cursor_col,
                      rsp_payload.cursor_col);
               mismatches++;
            end
            if (rsp_payload.quit !== want.quit) begin
               $error("quit expected %0b actual %0b", want.quit, rsp_payload.quit);
               mismatches++;
            end
         end
      end
      rsp_ready <= steady || ($urandom_range(0, 99) >= 30);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
